[src/mgb_pkg.sv]
// ----------------------------------------------------------------------------
// mgb_pkg
// Shared constants, configuration and queue item types of the glyph blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mgb_pkg;

  localparam int FONT_WORDS     = 4096;
  localparam int FONT_AW        = $clog2(FONT_WORDS);
  localparam int MAX_GLYPH_SIDE = 8;

  // Clamped cell side (0..MAX_GLYPH_SIDE) and offsets inside a cell.
  localparam int SIDE_W = $clog2(MAX_GLYPH_SIDE + 1);
  localparam int OFS_W  = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;

  localparam int CODE_W = 8;
  localparam int PROD_W = CODE_W + SIDE_W;
  localparam int FRB_W  = 13;
  localparam int DW_W   = 11;
  localparam int COL_W  = 16;
  localparam int CLIP_W = 10;
  localparam int ADDR_W = 20;
  localparam int POS_W  = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_ROW_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef struct packed {
    logic [3:0]        gw;
    logic [3:0]        gh;
    logic [FRB_W-1:0]  frb;
    logic [COL_W-1:0]  colour;
    logic [DW_W-1:0]   dw;
  } cfg_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic              kind;
    logic [FONT_AW-1:0] font_addr;
    logic [15:0]       font_word;
    logic [PROD_W-1:0] prod;
    logic [SIDE_W-1:0] h;
    logic [CLIP_W-1:0] sx;
    logic [CLIP_W-1:0] sy;
    logic [OFS_W-1:0]  dc0;
    logic [OFS_W-1:0]  dr0;
    logic [OFS_W-1:0]  ncm1;
    logic [OFS_W-1:0]  nrm1;
    logic              empty;
    logic [POS_W-1:0]  nx;
  } mgb_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_BASE,
    B_WALK,
    B_END,
    B_DRAIN
  } back_state_t;

endpackage

`default_nettype wire

[src/mgb_front.sv]
// ----------------------------------------------------------------------------
// mgb_front
// Accepts input items, clamps the cell, clips it to the box and classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module mgb_front import mgb_pkg::*; (
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [11:0]              in_font_address,
  input  logic [15:0]              in_font_word,
  input  logic [CODE_W-1:0]        in_glyph_code,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic [CLIP_W-1:0]        in_clip_left,
  input  logic [CLIP_W-1:0]        in_clip_top,
  input  logic [CLIP_W-1:0]        in_clip_right,
  input  logic [CLIP_W-1:0]        in_clip_bottom,
  input  logic                     q_full,
  output logic                     q_push,
  output mgb_item_t                q_item
);

  logic [SIDE_W-1:0] w;
  logic [SIDE_W-1:0] h;
  logic signed [17:0] x_s, y_s, w_s, h_s;
  logic signed [17:0] cl_s, ct_s, cr_s, cb_s;
  logic signed [17:0] xe_s, ye_s;
  logic signed [17:0] sx_s, ex_s, sy_s, ey_s;
  logic signed [17:0] dcx, drx, ncx, nrx;

  assign w = (cfg.gw > 4'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(cfg.gw);
  assign h = (cfg.gh > 4'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(cfg.gh);

  assign x_s  = 18'(in_pos_x);
  assign y_s  = 18'(in_pos_y);
  assign w_s  = signed'(18'(w));
  assign h_s  = signed'(18'(h));
  assign cl_s = signed'(18'(in_clip_left));
  assign ct_s = signed'(18'(in_clip_top));
  assign cr_s = signed'(18'(in_clip_right));
  assign cb_s = signed'(18'(in_clip_bottom));

  assign xe_s = x_s + w_s - 18'sd1;
  assign ye_s = y_s + h_s - 18'sd1;

  assign sx_s = (x_s > cl_s) ? x_s : cl_s;
  assign ex_s = (xe_s < cr_s) ? xe_s : cr_s;
  assign sy_s = (y_s > ct_s) ? y_s : ct_s;
  assign ey_s = (ye_s < cb_s) ? ye_s : cb_s;

  assign dcx = sx_s - x_s;
  assign drx = sy_s - y_s;
  assign ncx = ex_s - sx_s;
  assign nrx = ey_s - sy_s;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.kind      = in_kind;
    q_item.font_addr = in_font_address[FONT_AW-1:0];
    q_item.font_word = in_font_word;
    q_item.prod      = PROD_W'(in_glyph_code) * PROD_W'(w);
    q_item.h         = h;
    q_item.sx        = sx_s[CLIP_W-1:0];
    q_item.sy        = sy_s[CLIP_W-1:0];
    q_item.dc0       = dcx[OFS_W-1:0];
    q_item.dr0       = drx[OFS_W-1:0];
    q_item.ncm1      = ncx[OFS_W-1:0];
    q_item.nrm1      = nrx[OFS_W-1:0];
    // A transparent colour or an empty clipped cell writes nothing.
    q_item.empty     = (sx_s > ex_s) || (sy_s > ey_s) || (cfg.colour == '0);
    q_item.nx        = in_pos_x + POS_W'(w);
  end

endmodule

`default_nettype wire

[src/mgb_queue.sv]
// ----------------------------------------------------------------------------
// mgb_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mgb_queue import mgb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mgb_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output mgb_item_t head_item
);

  mgb_item_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/mgb_div.sv]
// ----------------------------------------------------------------------------
// mgb_div
// Restoring divider, one quotient bit per cycle, for the glyph row layout.
// ----------------------------------------------------------------------------
`default_nettype none

module mgb_div import mgb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [FRB_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quot,
  output logic [FRB_W-1:0]  rem
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] num_r;
  logic [FRB_W-1:0]  rem_r;
  logic [FRB_W-1:0]  den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [FRB_W:0]    trial;
  logic [FRB_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, num_r[PROD_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      // The quotient bits shift in where the dividend bits leave.
      num_r <= {num_r[PROD_W-2:0], ge};
      rem_r <= ge ? diff[FRB_W-1:0] : trial[FRB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/mgb_back.sv]
// ----------------------------------------------------------------------------
// mgb_back
// Executes queued items: font store writes, glyph setup and the cell walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mgb_back import mgb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    q_valid,
  input  mgb_item_t               q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_write_enable,
  output logic [ADDR_W-1:0]       out_pixel_address,
  output logic [COL_W-1:0]        out_pixel_colour,
  output logic signed [POS_W-1:0] out_next_x,
  output logic                    out_last
);

  back_state_t state_r, state_nxt;
  mgb_item_t   cur_r;

  logic              div_start, div_done;
  logic [PROD_W-1:0] div_quot;
  logic [FRB_W-1:0]  div_rem;

  logic [PROD_W-1:0] qt_r;
  logic [FRB_W-1:0]  rm_r;
  logic [15:0]       hq_r;
  logic [15:0]       offm_r;
  logic [ADDR_W-1:0] rowaddr_r;
  logic [15:0]       rowbase_r;
  logic [OFS_W-1:0]  cc_r, rc_r;

  logic [15:0] font_mem [FONT_WORDS];
  logic [15:0] rdata_r;
  logic        mem_we;

  logic              s2_valid_r, s2_end_r;
  logic [3:0]        s2_ofs_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic              hold_valid_r;
  logic [ADDR_W-1:0] hold_addr_r;

  logic              out_valid_r, out_we_r, out_last_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [COL_W-1:0]  out_colour_r;
  logic [POS_W-1:0]  out_nx_r;

  logic              en, walk_step, end_step, last_cell;
  logic [15:0]       hq_full, offm_full, base_mul, pos;
  logic [ADDR_W-1:0] rowaddr_full, paddr;
  logic [OFS_W:0]    dc;
  logic [CLIP_W-1:0] col;
  logic              bit_set;
  logic              push, push_we, push_last;
  logic [ADDR_W-1:0] push_addr;

  mgb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_item.prod),
    .divisor  (cfg.frb),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // The walk advances only when the output register can take an item.
  assign en        = !out_valid_r || out_ready;
  assign walk_step = (state_r == B_WALK) && en;
  assign end_step  = (state_r == B_END) && en;
  assign last_cell = (cc_r == cur_r.ncm1) && (rc_r == cur_r.nrm1);

  assign hq_full      = 16'(cur_r.h) * 16'(qt_r);
  assign offm_full    = 16'(cur_r.dr0) * 16'(cfg.frb);
  assign rowaddr_full = ADDR_W'(cur_r.sy) * ADDR_W'(cfg.dw);
  assign base_mul     = hq_r * 16'(cfg.frb);

  assign dc    = (OFS_W + 1)'(cur_r.dc0) + (OFS_W + 1)'(cc_r);
  assign pos   = rowbase_r + 16'(dc);
  assign col   = cur_r.sx + CLIP_W'(cc_r);
  assign paddr = rowaddr_r + ADDR_W'(col);

  // Font bits are stored leftmost pixel first, so offset zero is bit 15.
  assign bit_set = rdata_r[~s2_ofs_r];

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_LOAD) begin
            mem_we = 1'b1;
          end else if (q_item.empty) begin
            state_nxt = B_END;
          end else begin
            div_start = 1'b1;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL:  state_nxt = B_BASE;
      B_BASE: state_nxt = B_WALK;
      B_WALK: begin
        if (en && last_cell) begin
          state_nxt = B_END;
        end
      end
      B_END: begin
        if (en) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (en) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[q_item.font_addr] <= q_item.font_word;
    end
    if (walk_step) begin
      rdata_r <= font_mem[pos[FONT_AW+3:4]];
    end
  end

  // Glyph setup and walk counters.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (div_done) begin
      // A zero row width leaves the whole product as remainder.
      qt_r <= (cfg.frb == '0) ? '0 : div_quot;
      rm_r <= (cfg.frb == '0) ? FRB_W'(cur_r.prod) : div_rem;
    end
    if (state_r == B_MUL) begin
      hq_r      <= hq_full;
      offm_r    <= offm_full;
      rowaddr_r <= rowaddr_full;
    end
    if (state_r == B_BASE) begin
      rowbase_r <= 16'(rm_r) + base_mul + offm_r;
      cc_r      <= '0;
      rc_r      <= '0;
    end
    if (walk_step) begin
      if (cc_r == cur_r.ncm1) begin
        cc_r      <= '0;
        rc_r      <= rc_r + 1'b1;
        rowbase_r <= rowbase_r + 16'(cfg.frb);
        rowaddr_r <= rowaddr_r + ADDR_W'(cfg.dw);
      end else begin
        cc_r <= cc_r + 1'b1;
      end
    end
    if (en) begin
      s2_end_r  <= end_step;
      s2_ofs_r  <= pos[3:0];
      s2_addr_r <= paddr;
    end
  end

  // A write is held back by one so that the final one can carry the last flag.
  always_comb begin
    push      = 1'b0;
    push_we   = 1'b0;
    push_last = 1'b0;
    push_addr = hold_addr_r;
    if (en && s2_valid_r) begin
      if (s2_end_r) begin
        push      = 1'b1;
        push_we   = hold_valid_r;
        push_last = 1'b1;
        push_addr = hold_valid_r ? hold_addr_r : '0;
      end else if (bit_set && hold_valid_r) begin
        push    = 1'b1;
        push_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (en) begin
        s2_valid_r <= walk_step || end_step;
      end
      if (en && s2_valid_r) begin
        if (s2_end_r) begin
          hold_valid_r <= 1'b0;
        end else if (bit_set) begin
          hold_valid_r <= 1'b1;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid_r && !s2_end_r && bit_set) begin
      hold_addr_r <= s2_addr_r;
    end
    if (push) begin
      out_we_r     <= push_we;
      out_addr_r   <= push_addr;
      out_colour_r <= push_we ? cfg.colour : '0;
      out_nx_r     <= cur_r.nx;
      out_last_r   <= push_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_colour  = out_colour_r;
  assign out_next_x        = signed'(out_nx_r);
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

[src/mono_glyph_blitter.sv]
// ----------------------------------------------------------------------------
// mono_glyph_blitter
// Monochrome font glyph blitter with clipping; top level and register file.
// ----------------------------------------------------------------------------
// Load items (kind 0) write one 16-bit word of the font store and give no
// result. Draw items (kind 1) give one pixel write per set font bit inside the
// clip box, in raster order, the final one flagged last; a draw that writes
// nothing gives a single item with write_enable low and last high. Every
// result carries next_x. Both channels transfer on valid and ready high.
// The front clips each item and queues it, two entries deep, so the input
// keeps taking items while the back is busy, until the queue is full. A load
// writes the font store as it is popped. A draw's setup runs through the pop,
// a 12-step restoring divider, the hand-over of its result and the multiply
// and base states; the walk then visits one cell of the clipped box per cycle
// while the output can take items, at one font store read per cell, and the
// end and drain states close the draw. A stalled receiver holds the walk;
// the output register keeps its item. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata by the user only while the block
// is idle; the block does not enforce it. Synchronous reset empties the
// queue and the pipeline and restores the register defaults; the font store
// keeps no reset value and must be loaded before drawing.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_glyph_blitter import mgb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [11:0]              in_font_address,
  input  logic [15:0]              in_font_word,
  input  logic [CODE_W-1:0]        in_glyph_code,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic [CLIP_W-1:0]        in_clip_left,
  input  logic [CLIP_W-1:0]        in_clip_top,
  input  logic [CLIP_W-1:0]        in_clip_right,
  input  logic [CLIP_W-1:0]        in_clip_bottom,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_write_enable,
  output logic [ADDR_W-1:0]        out_pixel_address,
  output logic [COL_W-1:0]         out_pixel_colour,
  output logic signed [POS_W-1:0]  out_next_x,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  cfg_t      cfg_r;
  logic      q_full, q_push, q_pop, q_valid;
  mgb_item_t front_item, head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gw     <= 4'd8;
      cfg_r.gh     <= 4'd8;
      cfg_r.frb    <= 13'd2048;
      cfg_r.colour <= 16'hFFFF;
      cfg_r.dw     <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLYPH_WIDTH:   cfg_r.gw     <= cfg_wdata[3:0];
        CFG_GLYPH_HEIGHT:  cfg_r.gh     <= cfg_wdata[3:0];
        CFG_FONT_ROW_BITS: cfg_r.frb    <= cfg_wdata[FRB_W-1:0];
        CFG_DRAW_COLOUR:   cfg_r.colour <= cfg_wdata[COL_W-1:0];
        CFG_DEST_WIDTH:    cfg_r.dw     <= cfg_wdata[DW_W-1:0];
        default: ;
      endcase
    end
  end

  mgb_front u_front (
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_font_address (in_font_address),
    .in_font_word    (in_font_word),
    .in_glyph_code   (in_glyph_code),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_clip_left    (in_clip_left),
    .in_clip_top     (in_clip_top),
    .in_clip_right   (in_clip_right),
    .in_clip_bottom  (in_clip_bottom),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (front_item)
  );

  mgb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  mgb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (head_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_enable  (out_write_enable),
    .out_pixel_address (out_pixel_address),
    .out_pixel_colour  (out_pixel_colour),
    .out_next_x        (out_next_x),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
